[hw/rtl/xsed_pkg.sv]
// shared types, codes and helpers for the cross-reference stream entry decoder
package xsed_pkg;

  // widest field in bytes, and the longest entry that three such fields make
  localparam int unsigned MAX_FIELD_BYTES = 8;
  localparam int unsigned MAX_ENTRY_BYTES = 3 * MAX_FIELD_BYTES;
  localparam int unsigned POS_W           = $clog2(MAX_ENTRY_BYTES);

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // configuration register indexes
  localparam logic [1:0] REG_TYPE_WIDTH      = 2'd0;
  localparam logic [1:0] REG_FIELD_ONE_WIDTH = 2'd1;
  localparam logic [1:0] REG_FIELD_TWO_WIDTH = 2'd2;

  // width register reset values
  localparam logic [3:0] TYPE_WIDTH_RST      = 4'd1;
  localparam logic [3:0] FIELD_ONE_WIDTH_RST = 4'd2;
  localparam logic [3:0] FIELD_TWO_WIDTH_RST = 4'd1;

  // item operation codes
  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_DATA   = 1'b1;

  // entry error codes
  localparam logic [1:0] ERR_OK           = 2'd0;
  localparam logic [1:0] ERR_TYPE_WIDTH   = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN_TYPE = 2'd2;

  // highest known entry type (compressed)
  localparam logic [63:0] TYPE_MAX = 64'd2;

  // classified item as it travels from front to back
  typedef struct packed {
    logic        op;
    logic [7:0]  data_byte;
    logic [31:0] first_object;
    logic [31:0] entry_count;
  } xsed_item_t;

  // field widths as the back part sees them
  typedef struct packed {
    logic [3:0] type_width;
    logic [3:0] field_one_width;
    logic [3:0] field_two_width;
  } xsed_cfg_t;

  // widths above the field limit count as the limit
  function automatic logic [3:0] clamp_width(input logic [3:0] w);
    clamp_width = (w > 4'(MAX_FIELD_BYTES)) ? 4'(MAX_FIELD_BYTES) : w;
  endfunction

endpackage

[hw/rtl/xsed_front.sv]
// front part: accepts input items, classifies them and hands them to the queue
module xsed_front
  import xsed_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [7:0] in_data_byte,
  input  logic [31:0] in_first_object,
  input  logic [31:0] in_entry_count,
  output logic       push_valid,
  input  logic       push_ready,
  output xsed_item_t push_item
);

  logic       hold_valid_r, hold_valid_nxt;
  xsed_item_t hold_item_r;
  xsed_item_t cls_item;

  // classify: header items keep only their numbers, data items only the byte
  always_comb begin
    cls_item = '0;
    if (in_kind == OP_DATA) begin
      cls_item.op        = OP_DATA;
      cls_item.data_byte = in_data_byte;
    end else begin
      cls_item.op           = OP_HEADER;
      cls_item.first_object = in_first_object;
      cls_item.entry_count  = in_entry_count;
    end
  end

  // one holding stage, refilled in the same cycle it drains
  assign in_ready   = !hold_valid_r || push_ready;
  assign push_valid = hold_valid_r;
  assign push_item  = hold_item_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_ready) begin
      hold_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item_r <= cls_item;
    end
  end

endmodule

[hw/rtl/xsed_queue.sv]
// short queue between front and back
module xsed_queue
  import xsed_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  xsed_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output xsed_item_t pop_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  xsed_item_t         store [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = store[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr_r] <= push_item;
    end
  end

  // fill count stays within the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  // empty queue means both pointers meet
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue empty with pointers apart");

  // a pop without a push lowers the count by one
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("queue count not lowered on pop");

endmodule

[hw/rtl/xsed_back.sv]
// back part: accumulates entry bytes, numbers entries and registers results
module xsed_back
  import xsed_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  xsed_cfg_t   cfg,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  xsed_item_t  pop_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_entry_type,
  output logic [31:0] out_object_number,
  output logic [63:0] out_field_one,
  output logic [63:0] out_field_two,
  output logic [1:0]  out_error_code,
  output logic [31:0] out_greatest_object
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [63:0]      type_acc_r, type_acc_nxt;
  logic [63:0]      one_acc_r, one_acc_nxt;
  logic [63:0]      two_acc_r, two_acc_nxt;
  logic [31:0]      cur_obj_r, cur_obj_nxt;
  logic [31:0]      remain_r, remain_nxt;
  logic             unlimited_r, unlimited_nxt;
  logic [31:0]      largest_r, largest_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [7:0]       res_type;
  logic [63:0]      res_one, res_two;
  logic [1:0]       res_err;
  logic             res_load;

  logic [3:0]       tw, w1, w2;
  logic [POS_W:0]   total, tw_end, w1_end, pos_inc;
  logic             do_pop, active, done;
  logic [63:0]      type_acc_w, one_acc_w, two_acc_w;

  assign tw      = clamp_width(cfg.type_width);
  assign w1      = clamp_width(cfg.field_one_width);
  assign w2      = clamp_width(cfg.field_two_width);
  assign tw_end  = (POS_W+1)'(tw);
  assign w1_end  = tw_end + (POS_W+1)'(w1);
  assign total   = w1_end + (POS_W+1)'(w2);
  assign pos_inc = (POS_W+1)'(pos_r) + (POS_W+1)'(1);

  // the output register frees up when empty or being taken
  assign pop_ready = !out_valid_r || out_ready;
  assign do_pop    = pop_valid && pop_ready;
  assign active    = unlimited_r || (remain_r != '0);

  // place the byte into the field that the position falls in
  always_comb begin
    type_acc_w = type_acc_r;
    one_acc_w  = one_acc_r;
    two_acc_w  = two_acc_r;
    if (total != '0) begin
      if ((POS_W+1)'(pos_r) < tw_end) begin
        type_acc_w = {type_acc_r[55:0], pop_item.data_byte};
      end else if ((POS_W+1)'(pos_r) < w1_end) begin
        one_acc_w = {one_acc_r[55:0], pop_item.data_byte};
      end else begin
        two_acc_w = {two_acc_r[55:0], pop_item.data_byte};
      end
    end
    done = (total == '0) || (pos_inc >= total);
  end

  // entry state, numbering and result selection
  always_comb begin
    pos_nxt       = pos_r;
    type_acc_nxt  = type_acc_r;
    one_acc_nxt   = one_acc_r;
    two_acc_nxt   = two_acc_r;
    cur_obj_nxt   = cur_obj_r;
    remain_nxt    = remain_r;
    unlimited_nxt = unlimited_r;
    largest_nxt   = largest_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_load      = 1'b0;
    res_type      = type_acc_w[7:0];
    res_one       = one_acc_w;
    res_two       = two_acc_w;
    if (tw != 4'd1) begin
      res_err = ERR_TYPE_WIDTH;
    end else if (type_acc_w > TYPE_MAX) begin
      res_err = ERR_UNKNOWN_TYPE;
    end else begin
      res_err = ERR_OK;
    end
    if (do_pop) begin
      if (pop_item.op == OP_HEADER) begin
        cur_obj_nxt   = pop_item.first_object;
        remain_nxt    = pop_item.entry_count;
        unlimited_nxt = 1'b0;
        pos_nxt       = '0;
        type_acc_nxt  = '0;
        one_acc_nxt   = '0;
        two_acc_nxt   = '0;
      end else if (active) begin
        if (!done) begin
          pos_nxt      = pos_inc[POS_W-1:0];
          type_acc_nxt = type_acc_w;
          one_acc_nxt  = one_acc_w;
          two_acc_nxt  = two_acc_w;
        end else begin
          res_load      = 1'b1;
          out_valid_nxt = 1'b1;
          if ((res_err == ERR_OK) && (cur_obj_r > largest_r)) begin
            largest_nxt = cur_obj_r;
          end
          cur_obj_nxt = cur_obj_r + 32'd1;
          if (!unlimited_r) begin
            remain_nxt = remain_r - 32'd1;
          end
          pos_nxt      = '0;
          type_acc_nxt = '0;
          one_acc_nxt  = '0;
          two_acc_nxt  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      type_acc_r  <= '0;
      one_acc_r   <= '0;
      two_acc_r   <= '0;
      cur_obj_r   <= '0;
      remain_r    <= '0;
      unlimited_r <= 1'b1;
      largest_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      type_acc_r  <= type_acc_nxt;
      one_acc_r   <= one_acc_nxt;
      two_acc_r   <= two_acc_nxt;
      cur_obj_r   <= cur_obj_nxt;
      remain_r    <= remain_nxt;
      unlimited_r <= unlimited_nxt;
      largest_r   <= largest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_entry_type      <= res_type;
      out_object_number   <= cur_obj_r;
      out_field_one       <= res_one;
      out_field_two       <= res_two;
      out_error_code      <= res_err;
      out_greatest_object <= largest_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // byte position never reaches the longest entry
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (POS_W+1)'(pos_r) < (POS_W+1)'(MAX_ENTRY_BYTES))
    else $error("byte position past longest entry");

  // a clean entry is never above the running greatest number
  a_greatest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_error_code == ERR_OK)) |->
      (out_greatest_object >= out_object_number))
    else $error("greatest object below clean entry number");

  // a completed entry advances numbering by one
  a_numbering: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (cur_obj_r == out_object_number + 32'd1))
    else $error("object number not advanced after entry");

endmodule

[hw/rtl/xref_stream_entry_decoder.sv]
// top level of the cross-reference stream entry decoder
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    kind, data byte, first object, entry count
//   out      output     out_valid / out_ready  type, object, two fields, error, greatest
//   cfg      input      cfg_valid / cfg_ready  register index, 4-bit width value
//
// one item per cycle sustained while the output is not stalled; the back part's byte
// accumulate and numbering step sets that figure. The last byte of an entry passes the
// front holding stage, the queue and the output register before out_valid rises, and
// is held back further only while the output or the queue is stalled.
// synchronous active-low reset clears all control state; no clearing pass.
// a stalled output holds its result while the front and queue keep taking items
// until the queue fills.
module xref_stream_entry_decoder
  import xsed_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  input  logic [31:0] in_first_object,
  input  logic [31:0] in_entry_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_entry_type,
  output logic [31:0] out_object_number,
  output logic [63:0] out_field_one,
  output logic [63:0] out_field_two,
  output logic [1:0]  out_error_code,
  output logic [31:0] out_greatest_object,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  xsed_cfg_t  cfg_r;
  xsed_item_t push_item, pop_item;
  logic       push_valid, push_ready, pop_valid, pop_ready;

  // width registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.type_width      <= TYPE_WIDTH_RST;
      cfg_r.field_one_width <= FIELD_ONE_WIDTH_RST;
      cfg_r.field_two_width <= FIELD_TWO_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TYPE_WIDTH:      cfg_r.type_width      <= cfg_data;
        REG_FIELD_ONE_WIDTH: cfg_r.field_one_width <= cfg_data;
        REG_FIELD_TWO_WIDTH: cfg_r.field_two_width <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  xsed_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_data_byte    (in_data_byte),
    .in_first_object (in_first_object),
    .in_entry_count  (in_entry_count),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_item       (push_item)
  );

  xsed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  xsed_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .pop_valid           (pop_valid),
    .pop_ready           (pop_ready),
    .pop_item            (pop_item),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_entry_type      (out_entry_type),
    .out_object_number   (out_object_number),
    .out_field_one       (out_field_one),
    .out_field_two       (out_field_two),
    .out_error_code      (out_error_code),
    .out_greatest_object (out_greatest_object)
  );

endmodule

[tb/tb_xref_stream_entry_decoder.sv]
// self-checking testbench: decoded entries checked against an in-bench entry decoder
module tb_xref_stream_entry_decoder;
  import xsed_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned ITEM_TARGET  = 600;
  localparam int unsigned MAX_REPORTS  = 60;
  // index with no register behind it, writes must be dropped
  localparam logic [1:0]  REG_SPARE    = 2'd3;

  typedef struct packed {
    logic [7:0]  etype;
    logic [31:0] obj;
    logic [63:0] f_one;
    logic [63:0] f_two;
    logic [1:0]  err;
    logic [31:0] greatest;
  } entry_result_t;

  typedef struct {
    bit            is_cfg;
    logic [1:0]    reg_idx;
    logic [3:0]    reg_val;
    logic          kind;
    logic [7:0]    data;
    logic [31:0]   first_obj;
    logic [31:0]   count;
    bit            typed;
    entry_result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic        in_kind         = OP_HEADER;
  logic [7:0]  in_data_byte    = '0;
  logic [31:0] in_first_object = '0;
  logic [31:0] in_entry_count  = '0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [7:0]  out_entry_type;
  logic [31:0] out_object_number;
  logic [63:0] out_field_one;
  logic [63:0] out_field_two;
  logic [1:0]  out_error_code;
  logic [31:0] out_greatest_object;
  logic        cfg_valid       = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index       = '0;
  logic [3:0]  cfg_data        = '0;

  // entry decoder copy: widths, entry in progress, numbering
  logic [3:0]  cfg_w_type, cfg_w_one, cfg_w_two;
  logic [4:0]  ent_pos;
  logic [63:0] acc_type, acc_one, acc_two;
  logic [31:0] obj_next, obj_left, obj_top;
  bit          obj_unbounded;

  entry_result_t expected_entries[$];
  entry_result_t want_r;
  stim_row_t     steps[$];
  int unsigned   errors      = 0;
  int unsigned   took_items  = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   ready_hold  = 0;
  bit            burst       = 0;

  xref_stream_entry_decoder u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_data_byte        (in_data_byte),
    .in_first_object     (in_first_object),
    .in_entry_count      (in_entry_count),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_entry_type      (out_entry_type),
    .out_object_number   (out_object_number),
    .out_field_one       (out_field_one),
    .out_field_two       (out_field_two),
    .out_error_code      (out_error_code),
    .out_greatest_object (out_greatest_object),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // widths above eight bytes act as eight
  function automatic int unsigned field_bytes(input logic [3:0] w);
    return (w > 4'd8) ? 8 : int'(w);
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [3:0] pick_width(input bit for_type);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (for_type) return (r < 75) ? 4'd1 : 4'($urandom_range(0, 15));
    if (r < 60) return 4'($urandom_range(0, 3));
    if (r < 75) return 4'd8;
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (errors < MAX_REPORTS)
      $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  task automatic clear_entry();
    ent_pos  = '0;
    acc_type = '0;
    acc_one  = '0;
    acc_two  = '0;
  endtask

  // one item through the decoder copy; made is high when an entry completes
  task automatic decode_item(input logic kind, input logic [7:0] data,
                             input logic [31:0] first_obj, input logic [31:0] count,
                             output bit made, output entry_result_t res);
    int unsigned tw, w1, w2, total, p;
    logic [1:0]  err;
    made = 0;
    res  = '0;
    // header opens a subsection and drops any partial entry
    if (kind == OP_HEADER) begin
      obj_next      = first_obj;
      obj_left      = count;
      obj_unbounded = 0;
      clear_entry();
      return;
    end
    // count used up: byte is dropped
    if (!obj_unbounded && obj_left == 0)
      return;
    tw    = field_bytes(cfg_w_type);
    w1    = field_bytes(cfg_w_one);
    w2    = field_bytes(cfg_w_two);
    total = tw + w1 + w2;
    p     = ent_pos;
    // place byte by current widths; all-zero widths complete at once
    if (total != 0) begin
      if (p < tw)
        acc_type = {acc_type[55:0], data};
      else if (p < tw + w1)
        acc_one = {acc_one[55:0], data};
      else
        acc_two = {acc_two[55:0], data};
      if (p + 1 < total) begin
        ent_pos = 5'(p + 1);
        return;
      end
    end
    if (tw != 1)
      err = ERR_TYPE_WIDTH;
    else if (acc_type > TYPE_MAX)
      err = ERR_UNKNOWN_TYPE;
    else
      err = ERR_OK;
    if (err == ERR_OK && obj_next > obj_top)
      obj_top = obj_next;
    res  = '{acc_type[7:0], obj_next, acc_one, acc_two, err, obj_top};
    made = 1;
    obj_next = obj_next + 32'd1;
    if (!obj_unbounded)
      obj_left = obj_left - 32'd1;
    clear_entry();
  endtask

  // drive one item, hold it until taken, then predict
  task automatic send_item(input logic kind, input logic [7:0] data,
                           input logic [31:0] first_obj, input logic [31:0] count,
                           input bit typed, input entry_result_t want);
    int unsigned   gap;
    bit            made;
    entry_result_t res;
    gap = burst ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_data_byte    <= data;
    in_first_object <= first_obj;
    in_entry_count  <= count;
    do @(posedge clk); while (!in_ready);
    decode_item(kind, data, first_obj, count, made, res);
    if (made) expected_entries.insert(expected_entries.size(), typed ? want : res);
    took_items++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TYPE_WIDTH:      cfg_w_type = val;
      REG_FIELD_ONE_WIDTH: cfg_w_one  = val;
      REG_FIELD_TWO_WIDTH: cfg_w_two  = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // wait until every result is out and the pipeline has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_data(input logic [7:0] data, input bit typed = 0,
                          input entry_result_t want = '0);
    stim_row_t r;
    r.is_cfg    = 0;
    r.reg_idx   = '0;
    r.reg_val   = '0;
    r.kind      = OP_DATA;
    r.data      = data;
    r.first_obj = $urandom;
    r.count     = $urandom;
    r.typed     = typed;
    r.want      = want;
    steps.insert(steps.size(), r);
  endtask

  task automatic add_header(input logic [31:0] first_obj, input logic [31:0] count);
    stim_row_t r;
    r.is_cfg    = 0;
    r.reg_idx   = '0;
    r.reg_val   = '0;
    r.kind      = OP_HEADER;
    r.data      = 8'($urandom);
    r.first_obj = first_obj;
    r.count     = count;
    r.typed     = 0;
    r.want      = '0;
    steps.insert(steps.size(), r);
  endtask

  task automatic add_cfg(input logic [1:0] idx, input logic [3:0] val);
    stim_row_t r;
    r.is_cfg    = 1;
    r.reg_idx   = idx;
    r.reg_val   = val;
    r.kind      = OP_DATA;
    r.data      = '0;
    r.first_obj = '0;
    r.count     = '0;
    r.typed     = 0;
    r.want      = '0;
    steps.insert(steps.size(), r);
  endtask

  // one random phase: mostly whole entries, some headers and stray bytes
  task automatic gen_phase(input int unsigned n);
    int unsigned tw, total, sent, r;
    logic [31:0] first_obj, count;
    logic [7:0]  b;
    tw    = field_bytes(cfg_w_type);
    total = tw + field_bytes(cfg_w_one) + field_bytes(cfg_w_two);
    sent  = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        r = $urandom_range(0, 99);
        if (r < 30)
          first_obj = 32'hFFFF_FFFF - 32'($urandom_range(0, 4));
        else if (r < 60)
          first_obj = 32'($urandom_range(0, 50));
        else
          first_obj = $urandom;
        count = ($urandom_range(0, 99) < 80) ? 32'($urandom_range(0, 10)) : $urandom;
        send_item(OP_HEADER, 8'($urandom), first_obj, count, 1'b0, '0);
        sent++;
      end else if (r < 13 || total == 0) begin
        send_item(OP_DATA, 8'($urandom), $urandom, $urandom, 1'b0, '0);
        sent++;
      end else begin
        for (int i = 0; i < total; i++) begin
          if (i == 0 && tw == 1 && $urandom_range(0, 99) < 85)
            b = 8'($urandom_range(0, 2));
          else
            b = 8'($urandom);
          send_item(OP_DATA, b, $urandom, $urandom, 1'b0, '0);
          sent++;
        end
      end
    end
    // sometimes leave an entry half done across the next width change
    if ($urandom_range(0, 1) == 1)
      repeat ($urandom_range(1, 3))
        send_item(OP_DATA, 8'($urandom), $urandom, $urandom, 1'b0, '0);
  endtask

  // result side: random stalls, steady during bursts
  always @(posedge clk) begin
    if (!rst_n || burst) begin
      out_ready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold--;
    end else if ($urandom_range(0, 99) < 65) begin
      out_ready  <= 1'b1;
      ready_hold = $urandom_range(0, 12);
    end else begin
      out_ready  <= 1'b0;
      ready_hold = pick_gap();
    end
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_entries.size() == 0) begin
        note_mismatch("unexpected entry, object", 64'(out_object_number), '0);
      end else begin
        want_r = expected_entries.pop_front();
        if (out_entry_type !== want_r.etype)
          note_mismatch("entry_type", 64'(out_entry_type), 64'(want_r.etype));
        if (out_object_number !== want_r.obj)
          note_mismatch("object_number", 64'(out_object_number), 64'(want_r.obj));
        if (out_field_one !== want_r.f_one)
          note_mismatch("field_one", out_field_one, want_r.f_one);
        if (out_field_two !== want_r.f_two)
          note_mismatch("field_two", out_field_two, want_r.f_two);
        if (out_error_code !== want_r.err)
          note_mismatch("error_code", 64'(out_error_code), 64'(want_r.err));
        if (out_greatest_object !== want_r.greatest)
          note_mismatch("greatest_object", 64'(out_greatest_object), 64'(want_r.greatest));
      end
    end
  end

  // watchdog on cycles where no channel moves an item
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    // decoder copy after reset
    cfg_w_type    = TYPE_WIDTH_RST;
    cfg_w_one     = FIELD_ONE_WIDTH_RST;
    cfg_w_two     = FIELD_TWO_WIDTH_RST;
    clear_entry();
    obj_next      = '0;
    obj_left      = '0;
    obj_top       = '0;
    obj_unbounded = 1;

    // reset widths 1/2/1, unlimited count from object 0
    add_data(8'h01);
    add_data(8'hFF);
    add_data(8'hFF);
    add_data(8'hFF, 1, '{8'h01, 32'd0, 64'hFFFF, 64'hFF, ERR_OK, 32'd0});
    // unknown type keeps its number but not the greatest
    add_data(8'hFF);
    add_data(8'h00);
    add_data(8'h00);
    add_data(8'h00, 1, '{8'hFF, 32'd1, 64'h0, 64'h0, ERR_UNKNOWN_TYPE, 32'd0});
    // header mid-entry drops the partial entry
    add_header(32'hFFFF_FFFF, 32'd2);
    add_data(8'h02);
    add_header(32'hFFFF_FFFF, 32'd2);
    // free entry at the top number, then wrap to zero
    add_data(8'h00);
    add_data(8'h12);
    add_data(8'h34);
    add_data(8'h56);
    add_data(8'h02);
    add_data(8'h00);
    add_data(8'h07);
    add_data(8'h03);
    // count used up, and an empty subsection
    add_data(8'h55);
    add_header(32'd0, 32'd0);
    add_data(8'hAA);
    // all widths zero: each byte is a whole entry, type width error
    add_cfg(REG_TYPE_WIDTH, 4'd0);
    add_cfg(REG_FIELD_ONE_WIDTH, 4'd0);
    add_cfg(REG_FIELD_TWO_WIDTH, 4'd0);
    add_header(32'h8000_0000, 32'hFFFF_FFFF);
    add_data(8'hA5, 1, '{8'h00, 32'h8000_0000, 64'h0, 64'h0, ERR_TYPE_WIDTH,
                         32'hFFFF_FFFF});
    // two-byte type field reports its low byte
    add_cfg(REG_TYPE_WIDTH, 4'd2);
    add_data(8'h00);
    add_data(8'h07);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        settle();
        write_reg(steps[i].reg_idx, steps[i].reg_val);
      end else begin
        send_item(steps[i].kind, steps[i].data, steps[i].first_obj, steps[i].count,
                  steps[i].typed, steps[i].want);
      end
    end

    // random phases, widths changed only when drained
    phase = 0;
    while (took_items < ITEM_TARGET) begin
      settle();
      case (phase)
        0: begin
          write_reg(REG_TYPE_WIDTH, 4'd1);
          write_reg(REG_FIELD_ONE_WIDTH, 4'd8);
          write_reg(REG_FIELD_TWO_WIDTH, 4'd8);
          write_reg(REG_SPARE, 4'($urandom));
        end
        1: begin
          write_reg(REG_TYPE_WIDTH, 4'd15);
          write_reg(REG_FIELD_ONE_WIDTH, 4'd15);
          write_reg(REG_FIELD_TWO_WIDTH, 4'd15);
        end
        default: begin
          write_reg(REG_TYPE_WIDTH, pick_width(1'b1));
          write_reg(REG_FIELD_ONE_WIDTH, pick_width(1'b0));
          write_reg(REG_FIELD_TWO_WIDTH, pick_width(1'b0));
        end
      endcase
      burst = ($urandom_range(0, 4) == 0);
      gen_phase($urandom_range(20, 80));
      burst = 0;
      phase++;
    end

    settle();
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
